FILE: sv/ssd_pkg.sv
// Shared types, constants and the character table of the seven-segment scan driver.
// No dependencies; ssd_front and the top level import this package.
package ssd_pkg;

    localparam int SEGMENTS   = 8;
    localparam int DIGITS     = 3;
    localparam int SEG_IDX_W  = 3;
    localparam int DIGIT_W    = 2;
    localparam int CODE_W     = 5;
    localparam int NUMBER_W   = 16;
    localparam int POSITION_W = 2;
    localparam int SEG_W      = 8;

    localparam logic [CODE_W-1:0] MINUS_CODE = 5'd20;
    localparam logic [SEG_W-1:0]  SEG_MASK   = 8'((9'd1 << SEGMENTS) - 9'd1);

    // x / 1000 == (x * DIV1000_K) >> DIV1000_SHIFT for any 16-bit x
    localparam logic [16:0] DIV1000_K     = 17'd67109;
    localparam int          DIV1000_SHIFT = 26;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_BLINK = 2'd2,
        KIND_CODE  = 2'd3
    } t_kind;

    typedef enum logic {
        CFG_BLINK_ENABLE = 1'b0,
        CFG_SCAN_MODE    = 1'b1
    } t_cfg_index;

    typedef struct packed {
        t_kind                 kind;
        logic [NUMBER_W-1:0]   number;
        logic [POSITION_W-1:0] position;
        logic [CODE_W-1:0]     char_code;
    } t_item;

    // one item plus the partial results of the decimal split
    typedef struct packed {
        t_item      item;
        logic [6:0] q;      // number / 1000
        logic [9:0] r;      // number % 1000
        logic [3:0] h;      // hundreds
        logic [6:0] rem;    // r % 100
        logic [3:0] t;      // tens
        logic [3:0] u;      // units
    } t_stage;

    function automatic logic [SEG_W-1:0] glyph(input logic [CODE_W-1:0] code);
        logic [SEG_W-1:0] p;
        case (code)
            5'd0:    p = 8'h3F;
            5'd1:    p = 8'h06;
            5'd2:    p = 8'h5B;
            5'd3:    p = 8'h4F;
            5'd4:    p = 8'h66;
            5'd5:    p = 8'h6D;
            5'd6:    p = 8'h7D;
            5'd7:    p = 8'h07;
            5'd8:    p = 8'h7F;
            5'd9:    p = 8'h6F;
            5'd10:   p = 8'h00;
            5'd11:   p = 8'h3E;
            5'd12:   p = 8'h1C;
            5'd13:   p = 8'h73;
            5'd14:   p = 8'h5E;
            5'd15:   p = 8'h54;
            5'd16:   p = 8'h78;
            5'd17:   p = 8'h39;
            5'd18:   p = 8'h77;
            5'd19:   p = 8'h38;
            5'd20:   p = 8'h40;
            5'd21:   p = 8'h79;
            5'd22:   p = 8'h71;
            default: p = 8'h00;
        endcase
        return p;
    endfunction

endpackage

FILE: sv/ssd_front.sv
// Input pipeline: registers each item and splits the load number into decimal digits.
// Depends on ssd_pkg.
module ssd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  ssd_pkg::t_item i_item,
    output logic           o_valid,
    output ssd_pkg::t_stage o_stage,
    input  logic           i_take
);
    import ssd_pkg::*;

    localparam int STAGES = 5;

    logic   [STAGES-1:0] r_valid;
    logic   [STAGES-1:0] n_valid;
    logic   [STAGES-1:0] w_adv;
    logic   [STAGES-1:0] w_load;
    t_stage              r_stage [STAGES];
    t_stage              n_stage [STAGES];

    logic [32:0] w_prod;
    logic [15:0] w_q1000;
    logic [15:0] w_r16;
    logic [15:0] w_hprod;
    logic [13:0] w_tprod;

    // handshake chain, collapses bubbles
    always_comb begin
        w_adv[STAGES-1] = r_valid[STAGES-1] && i_take;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_adv[k] = r_valid[k] && (!r_valid[k+1] || w_adv[k+1]);
        end
        o_ready   = !r_valid[0] || w_adv[0];
        w_load[0] = i_valid && o_ready;
        for (int k = 1; k < STAGES; k++) begin
            w_load[k] = w_adv[k-1];
        end
        for (int k = 0; k < STAGES; k++) begin
            n_valid[k] = w_load[k] ? 1'b1 : (w_adv[k] ? 1'b0 : r_valid[k]);
        end
    end

    // decimal split, one short step per stage
    always_comb begin
        w_prod  = 33'(r_stage[0].item.number) * 33'(DIV1000_K);
        w_q1000 = 16'(r_stage[1].q) * 16'd1000;
        w_r16   = r_stage[1].item.number - w_q1000;
        w_hprod = 16'(r_stage[2].r) * 16'd41;
        w_tprod = 14'(r_stage[3].rem) * 14'd103;

        n_stage[0]      = '0;
        n_stage[0].item = i_item;

        n_stage[1]      = r_stage[0];
        n_stage[1].q    = w_prod[DIV1000_SHIFT +: 7];

        n_stage[2]      = r_stage[1];
        n_stage[2].r    = w_r16[9:0];

        n_stage[3]      = r_stage[2];
        n_stage[3].h    = w_hprod[15:12];
        n_stage[3].rem  = 7'(r_stage[2].r - 10'(w_hprod[15:12]) * 10'd100);

        n_stage[4]      = r_stage[3];
        n_stage[4].t    = w_tprod[13:10];
        n_stage[4].u    = 4'(r_stage[3].rem - 7'(w_tprod[13:10]) * 7'd10);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < STAGES; k++) begin
            if (w_load[k]) begin
                r_stage[k] <= n_stage[k];
            end
        end
    end

    assign o_valid = r_valid[STAGES-1];
    assign o_stage = r_stage[STAGES-1];

endmodule

FILE: sv/seven_segment_scan_driver_top.sv
// Top level of the three-digit multiplexed seven-segment scan driver.
// Depends on ssd_pkg and ssd_front.
//
//  channel   direction  handshake               payload
//  s_*       in         s_tvalid / s_tready     tdata: number, position, char_code; tuser: kind
//  m_*       out        m_tvalid / m_tready     tdata: segments, digit_select
//  i_cfg_*   in         i_cfg_valid / o_cfg_ready  index 0 blink_enable, 1 scan_mode
//
//  One item per cycle sustained while no waiting result stalls a tick item. An accepted
//  item passes five front registers (decimal split), then the display state and the
//  output register load on the same edge when a tick item is taken.
//  Synchronous active-low reset: codes to minus, scan position and phase to zero.
//  A waiting result stalls only tick items at the state stage; the output
//  register frees in the same cycle it is taken. Config is always ready.
module seven_segment_scan_driver_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // number[15:0], position[17:16], char_code[22:18], zero
    input  logic [1:0]  s_tuser,    // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // segments[7:0], digit_select[10:8], zero
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic        i_cfg_data
);
    import ssd_pkg::*;

    t_item  w_in;
    logic   w_fv;
    t_stage w_fs;
    logic   w_take;
    logic   w_out_free;

    logic                   r_blink_en;
    logic                   r_scan_mode;
    logic [CODE_W-1:0]      r_codes [DIGITS];
    logic [CODE_W-1:0]      n_codes [DIGITS];
    logic [SEG_IDX_W-1:0]   r_seg;
    logic [SEG_IDX_W-1:0]   n_seg;
    logic [DIGIT_W-1:0]     r_digit;
    logic [DIGIT_W-1:0]     n_digit;
    logic                   r_phase;
    logic                   n_phase;

    logic                   r_out_valid;
    logic [SEG_W-1:0]       r_out_segs;
    logic [DIGITS-1:0]      r_out_sel;

    logic [DIGIT_W-1:0]     w_d_cur;
    logic [DIGIT_W-1:0]     w_d_inc;
    logic [DIGIT_W-1:0]     w_d_show;
    logic [SEG_IDX_W:0]     w_seg_inc;
    logic [SEG_IDX_W-1:0]   w_seg_show;
    logic [SEG_W-1:0]       w_pattern;
    logic [SEG_W-1:0]       w_segs;
    logic [DIGITS-1:0]      w_sel;

    assign w_in.kind      = t_kind'(s_tuser);
    assign w_in.number    = s_tdata[15:0];
    assign w_in.position  = s_tdata[17:16];
    assign w_in.char_code = s_tdata[22:18];

    ssd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_item  (w_in),
        .o_valid (w_fv),
        .o_stage (w_fs),
        .i_take  (w_take)
    );

    assign w_out_free = !r_out_valid || m_tready;
    assign w_take     = w_fv && ((w_fs.item.kind != KIND_TICK) || w_out_free);

    // scan step
    always_comb begin
        w_d_cur   = (r_digit >= DIGIT_W'(DIGITS)) ? '0 : r_digit;
        w_d_inc   = (w_d_cur == DIGIT_W'(DIGITS - 1)) ? '0 : w_d_cur + DIGIT_W'(1);
        w_seg_inc = {1'b0, r_seg} + (SEG_IDX_W+1)'(1);
        if (!r_scan_mode) begin
            if (w_seg_inc >= (SEG_IDX_W+1)'(SEGMENTS)) begin
                w_seg_show = '0;
                w_d_show   = w_d_inc;
            end else begin
                w_seg_show = w_seg_inc[SEG_IDX_W-1:0];
                w_d_show   = w_d_cur;
            end
            w_pattern = glyph(r_codes[w_d_show]);
            w_segs    = w_pattern & (SEG_W'(1) << w_seg_show) & SEG_MASK;
        end else begin
            w_seg_show = r_seg;
            w_d_show   = w_d_cur;
            w_pattern  = glyph(r_codes[w_d_show]);
            w_segs     = w_pattern & SEG_MASK;
        end
        w_sel = DIGITS'(1) << w_d_show;
        if (r_blink_en && !r_phase) begin
            w_sel = '0;
        end
    end

    always_comb begin
        n_codes = r_codes;
        n_seg   = r_seg;
        n_digit = r_digit;
        n_phase = r_phase;
        if (w_take) begin
            unique case (w_fs.item.kind)
                KIND_TICK: begin
                    n_seg   = w_seg_show;
                    n_digit = r_scan_mode ? w_d_inc : w_d_show;
                end
                KIND_LOAD: begin
                    n_codes[0] = CODE_W'(w_fs.h);
                    n_codes[1] = CODE_W'(w_fs.t);
                    n_codes[2] = CODE_W'(w_fs.u);
                end
                KIND_BLINK: begin
                    n_phase = !r_phase;
                end
                KIND_CODE: begin
                    if (w_fs.item.position < POSITION_W'(DIGITS)) begin
                        n_codes[w_fs.item.position[DIGIT_W-1:0]] = w_fs.item.char_code;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DIGITS; i++) begin
                r_codes[i] <= MINUS_CODE;
            end
            r_seg       <= '0;
            r_digit     <= '0;
            r_phase     <= 1'b0;
            r_blink_en  <= 1'b0;
            r_scan_mode <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_codes <= n_codes;
            r_seg   <= n_seg;
            r_digit <= n_digit;
            r_phase <= n_phase;
            if (i_cfg_valid) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_BLINK_ENABLE: r_blink_en  <= i_cfg_data;
                    CFG_SCAN_MODE:    r_scan_mode <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_take && (w_fs.item.kind == KIND_TICK)) begin
                r_out_valid <= 1'b1;
            end else if (m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take && (w_fs.item.kind == KIND_TICK)) begin
            r_out_segs <= w_segs;
            r_out_sel  <= w_sel;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign m_tvalid    = r_out_valid;
    assign m_tdata     = {5'b0, r_out_sel, r_out_segs};

endmodule

FILE: sv/ssd_checker.sv
// Port-level checks for the seven-segment scan driver, bound to the top level.
// Depends on seven_segment_scan_driver_top.
module ssd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> $onehot0(m_tdata[10:8]))
        else $error("digit drive not one-hot");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> m_tdata[15:11] == 5'd0)
        else $error("tdata padding not zero");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind seven_segment_scan_driver_top ssd_checker u_ssd_checker (.*);
